// File: rtl/bta_pkg.sv
`default_nettype none

package bta_pkg;

   localparam int HEAP_WORDS     = 1024;
   localparam int ADDR_W         = 10;
   localparam int TAG_W          = 11;
   localparam int SRCH_W         = ADDR_W + 1;
   localparam int SUM_W          = ADDR_W + 2;
   localparam int BYTES_W        = 16;
   localparam int BYTES_PER_WORD = 4;
   localparam int WORD_SHIFT     = $clog2(BYTES_PER_WORD);
   localparam int WORDS_W        = BYTES_W + 1 - WORD_SHIFT;
   localparam int SPLIT_MIN      = 3;
   localparam int TAG_OVERHEAD   = 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTES_W-1:0]  request_bytes;
      logic [ADDR_W-1:0]   block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] data_address;
      logic              granted;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/bta_ram.sv
`default_nettype none

module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/boundary_tag_heap_allocator.sv
// Boundary-tag first-fit heap allocator over a 1024-word tag memory. Start is
// taken when busy is low; each request gives exactly one result, driven on
// rsp_word for a single cycle with rsp_valid high, and the receiver cannot
// stall it. An allocate reads one tag per block that it walks over, then makes
// two tag writes, or four when the block is split; a zero-size allocate or one
// whose search pointer sits at the top of the heap answers straight from idle
// without walking any block. A free of a live block makes one or two tag reads
// and two tag writes; a free of word zero answers straight from idle, and a free
// whose header is not allocated or whose footer lies past the heap answers after
// reading only its header. The result strobe is registered from the last state,
// and a new request may be started in the same cycle as the strobe. After reset
// the block stays busy while it writes the tags of the initial free block.
`default_nettype none

module boundary_tag_heap_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bta_pkg::req_type req_word,
   output logic                  rsp_valid,
   output bta_pkg::rsp_type      rsp_word
);

   localparam logic [bta_pkg::SUM_W-1:0] HEAP_LIMIT = bta_pkg::SUM_W'(bta_pkg::HEAP_WORDS);

   typedef enum logic [3:0] {
      ST_INIT0,
      ST_INIT1,
      ST_IDLE,
      ST_A_CHK,
      ST_A_WR0,
      ST_A_WR1,
      ST_A_WR2,
      ST_A_WR3,
      ST_F_CHKH,
      ST_F_CHKN,
      ST_F_WR0,
      ST_F_WR1
   } state_type;

   state_type                       state_ff;
   logic [bta_pkg::SRCH_W-1:0]      search_ff;
   logic [bta_pkg::ADDR_W-1:0]      base_ff;
   logic [bta_pkg::WORDS_W-1:0]     words_ff;
   logic [bta_pkg::TAG_W-1:0]       mag_ff;
   logic [bta_pkg::TAG_W-1:0]       len_ff;
   logic [bta_pkg::TAG_W-1:0]       rest_ff;
   logic                            split_ff;
   logic                            rsp_valid_ff;
   bta_pkg::rsp_type                rsp_word_ff;

   logic                            ram_wr_en;
   logic [bta_pkg::ADDR_W-1:0]      ram_wr_addr;
   logic [bta_pkg::TAG_W-1:0]       ram_wr_data;
   logic                            ram_rd_en;
   logic [bta_pkg::ADDR_W-1:0]      ram_rd_addr;
   logic [bta_pkg::TAG_W-1:0]       rd_tag;

   logic                            rd_neg;
   logic [bta_pkg::TAG_W-1:0]       rd_mag;
   logic [bta_pkg::WORDS_W-1:0]     req_words;
   logic [bta_pkg::SUM_W-1:0]       chk_end;
   logic [bta_pkg::SUM_W-1:0]       chk_nxt;
   logic                            chk_fit;
   logic [bta_pkg::TAG_W-1:0]       chk_left;
   logic [bta_pkg::SUM_W-1:0]       free_foot;
   logic [bta_pkg::SUM_W-1:0]       free_next;
   logic [bta_pkg::SUM_W-1:0]       merge_next;
   logic [bta_pkg::SUM_W-1:0]       merge_end;
   logic                            merge_ok;
   logic [bta_pkg::TAG_W-1:0]       merged_len;
   logic [bta_pkg::ADDR_W-1:0]      head_addr;
   logic [bta_pkg::SUM_W-1:0]       alloc_srch;
   logic [bta_pkg::TAG_W-1:0]       neg_len;

   bta_ram #(
      .WIDTH (bta_pkg::TAG_W),
      .DEPTH (bta_pkg::HEAP_WORDS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_tag)
   );

   assign rd_neg     = rd_tag[bta_pkg::TAG_W-1];
   assign rd_mag     = rd_neg ? (~rd_tag + 1'b1) : rd_tag;
   assign req_words  = bta_pkg::WORDS_W'(({1'b0, req_word.request_bytes}
                       + 17'(bta_pkg::BYTES_PER_WORD - 1)) >> bta_pkg::WORD_SHIFT);
   assign chk_end    = bta_pkg::SUM_W'(base_ff) + bta_pkg::SUM_W'(rd_mag) + 1'b1;
   assign chk_nxt    = chk_end + 1'b1;
   assign chk_fit    = !rd_neg && (words_ff <= bta_pkg::WORDS_W'(rd_mag));
   assign chk_left   = rd_mag - words_ff[bta_pkg::TAG_W-1:0];
   assign free_foot  = bta_pkg::SUM_W'(base_ff) + bta_pkg::SUM_W'(rd_mag);
   assign free_next  = free_foot + 1'b1;
   assign merge_next = bta_pkg::SUM_W'(base_ff) + bta_pkg::SUM_W'(mag_ff) + 1'b1;
   assign merge_end  = merge_next + bta_pkg::SUM_W'(rd_tag) + 1'b1;
   assign merge_ok   = !rd_neg && (rd_tag != '0) && (merge_end < HEAP_LIMIT);
   assign merged_len = mag_ff + rd_tag + bta_pkg::TAG_W'(bta_pkg::TAG_OVERHEAD);
   assign head_addr  = base_ff - 1'b1;
   assign alloc_srch = bta_pkg::SUM_W'(base_ff) + bta_pkg::SUM_W'(len_ff)
                       + bta_pkg::SUM_W'(bta_pkg::TAG_OVERHEAD);
   assign neg_len    = ~len_ff + 1'b1;

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = search_ff[bta_pkg::ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            ram_rd_en = start;
            if (req_word.op == bta_pkg::OP_FREE) begin
               ram_rd_addr = req_word.block_address - 1'b1;
            end
         end
         ST_A_CHK: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = chk_nxt[bta_pkg::ADDR_W-1:0];
         end
         ST_F_CHKH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = free_next[bta_pkg::ADDR_W-1:0];
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = base_ff;
      ram_wr_data = neg_len;
      case (state_ff)
         ST_INIT0: begin
            ram_wr_addr = '0;
            ram_wr_data = bta_pkg::TAG_W'(bta_pkg::HEAP_WORDS - bta_pkg::TAG_OVERHEAD);
         end
         ST_INIT1: begin
            ram_wr_addr = bta_pkg::ADDR_W'(bta_pkg::HEAP_WORDS - 1);
            ram_wr_data = bta_pkg::TAG_W'(bta_pkg::HEAP_WORDS - bta_pkg::TAG_OVERHEAD);
         end
         ST_A_WR0: begin
            ram_wr_addr = base_ff;
            ram_wr_data = neg_len;
         end
         ST_A_WR1: begin
            ram_wr_addr = base_ff + bta_pkg::ADDR_W'(len_ff) + 1'b1;
            ram_wr_data = neg_len;
         end
         ST_A_WR2: begin
            ram_wr_addr = alloc_srch[bta_pkg::ADDR_W-1:0];
            ram_wr_data = rest_ff;
         end
         ST_A_WR3: begin
            ram_wr_addr = base_ff + bta_pkg::ADDR_W'(mag_ff) + 1'b1;
            ram_wr_data = rest_ff;
         end
         ST_F_WR0: begin
            ram_wr_addr = head_addr;
            ram_wr_data = len_ff;
         end
         ST_F_WR1: begin
            ram_wr_addr = base_ff + bta_pkg::ADDR_W'(len_ff);
            ram_wr_data = len_ff;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT0;
         search_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_INIT0: begin
               state_ff <= ST_INIT1;
            end
            ST_INIT1: begin
               state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  words_ff <= req_words;
                  if (req_word.op == bta_pkg::OP_FREE) begin
                     base_ff <= req_word.block_address;
                     if (req_word.block_address == '0) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_word_ff  <= '{data_address: '0, granted: 1'b0};
                     end else begin
                        state_ff <= ST_F_CHKH;
                     end
                  end else begin
                     base_ff <= search_ff[bta_pkg::ADDR_W-1:0];
                     if (req_words == '0 ||
                         search_ff >= bta_pkg::SRCH_W'(bta_pkg::HEAP_WORDS)) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_word_ff  <= '{data_address: '0, granted: 1'b0};
                     end else begin
                        state_ff <= ST_A_CHK;
                     end
                  end
               end
            end
            ST_A_CHK: begin
               if (rd_tag == '0 || chk_end >= HEAP_LIMIT) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{data_address: '0, granted: 1'b0};
                  state_ff     <= ST_IDLE;
               end else if (chk_fit) begin
                  mag_ff  <= rd_mag;
                  rest_ff <= chk_left - bta_pkg::TAG_W'(bta_pkg::TAG_OVERHEAD);
                  if (chk_left < bta_pkg::TAG_W'(bta_pkg::SPLIT_MIN)) begin
                     split_ff <= 1'b0;
                     len_ff   <= rd_mag;
                  end else begin
                     split_ff <= 1'b1;
                     len_ff   <= words_ff[bta_pkg::TAG_W-1:0];
                  end
                  state_ff <= ST_A_WR0;
               end else if (chk_nxt >= HEAP_LIMIT) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{data_address: '0, granted: 1'b0};
                  state_ff     <= ST_IDLE;
               end else begin
                  base_ff <= chk_nxt[bta_pkg::ADDR_W-1:0];
               end
            end
            ST_A_WR0: begin
               state_ff <= ST_A_WR1;
            end
            ST_A_WR1: begin
               if (split_ff) begin
                  state_ff <= ST_A_WR2;
               end else begin
                  search_ff    <= alloc_srch[bta_pkg::SRCH_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{data_address: base_ff + 1'b1, granted: 1'b1};
                  state_ff     <= ST_IDLE;
               end
            end
            ST_A_WR2: begin
               state_ff <= ST_A_WR3;
            end
            ST_A_WR3: begin
               search_ff    <= alloc_srch[bta_pkg::SRCH_W-1:0];
               rsp_valid_ff <= 1'b1;
               rsp_word_ff  <= '{data_address: base_ff + 1'b1, granted: 1'b1};
               state_ff     <= ST_IDLE;
            end
            ST_F_CHKH: begin
               if (!rd_neg || free_foot >= HEAP_LIMIT) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= '{data_address: '0, granted: 1'b0};
                  state_ff     <= ST_IDLE;
               end else begin
                  mag_ff <= rd_mag;
                  if (free_next >= HEAP_LIMIT) begin
                     len_ff   <= rd_mag;
                     state_ff <= ST_F_WR0;
                  end else begin
                     state_ff <= ST_F_CHKN;
                  end
               end
            end
            ST_F_CHKN: begin
               len_ff   <= merge_ok ? merged_len : mag_ff;
               state_ff <= ST_F_WR0;
            end
            ST_F_WR0: begin
               state_ff <= ST_F_WR1;
            end
            ST_F_WR1: begin
               if (search_ff > bta_pkg::SRCH_W'(head_addr)) begin
                  search_ff <= bta_pkg::SRCH_W'(head_addr);
               end
               rsp_valid_ff <= 1'b1;
               rsp_word_ff  <= '{data_address: '0, granted: 1'b1};
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_start_goes_busy_or_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither started work nor answered");

   a_address_only_when_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.data_address != '0) |-> rsp_word.granted)
      else $error("data address given without grant");

   a_search_in_heap: assert property (@(posedge clock) disable iff (reset)
      search_ff <= bta_pkg::SRCH_W'(bta_pkg::HEAP_WORDS))
      else $error("search pointer beyond heap");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !ram_wr_en)
      else $error("tag write while idle");

endmodule

`default_nettype wire

// File: test/heap_alloc_checker.sv
`default_nettype none

module heap_alloc_checker
   import bta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire bta_pkg::req_type req_word,
   input  wire logic             rsp_valid,
   input  wire bta_pkg::rsp_type rsp_word,
   output int                    mismatches,
   output int                    leftover
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [TAG_W-1:0] tag_mem [HEAP_WORDS];
   logic [SRCH_W-1:0]       scan_ptr;
   rsp_type                 expected_replies [$];

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   // first-fit walk from the scan pointer, forward-only coalescing on free
   function automatic rsp_type heap_step(input req_type w);
      rsp_type r;
      int      words, pos, mag, tg, nt, head, sz, foot, nxt, merged;
      logic    done;
      r = '0;
      if (w.op == OP_ALLOC) begin
         words = (int'(w.request_bytes) + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
         pos = int'(scan_ptr);
         done = (words == 0);
         while (!done && pos < HEAP_WORDS) begin
            tg = int'(tag_mem[pos]);
            mag = (tg < 0) ? -tg : tg;
            if (tg == 0 || pos + mag + 1 >= HEAP_WORDS) begin
               done = 1'b1;
            end else if (tg > 0 && words <= mag) begin
               if (mag - words < SPLIT_MIN) begin
                  tag_mem[pos] = TAG_W'(-mag);
                  tag_mem[pos + mag + 1] = TAG_W'(-mag);
                  scan_ptr = SRCH_W'(pos + mag + TAG_OVERHEAD);
               end else begin
                  tag_mem[pos] = TAG_W'(-words);
                  tag_mem[pos + words + 1] = TAG_W'(-words);
                  tag_mem[pos + words + 2] = TAG_W'(mag - words - TAG_OVERHEAD);
                  tag_mem[pos + mag + 1] = TAG_W'(mag - words - TAG_OVERHEAD);
                  scan_ptr = SRCH_W'(pos + words + TAG_OVERHEAD);
               end
               r.data_address = ADDR_W'(pos + 1);
               r.granted = 1'b1;
               done = 1'b1;
            end else begin
               pos += mag + TAG_OVERHEAD;
            end
         end
      end else if (w.block_address != '0) begin
         head = int'(w.block_address) - 1;
         tg = int'(tag_mem[head]);
         sz = -tg;
         foot = int'(w.block_address) + sz;
         if (tg < 0 && foot < HEAP_WORDS) begin
            nxt = foot + 1;
            nt = (nxt < HEAP_WORDS) ? int'(tag_mem[nxt]) : 0;
            if (nt > 0 && nxt + nt + 1 < HEAP_WORDS) begin
               merged = sz + nt + TAG_OVERHEAD;
               tag_mem[head] = TAG_W'(merged);
               tag_mem[int'(w.block_address) + merged] = TAG_W'(merged);
            end else begin
               tag_mem[head] = TAG_W'(sz);
               tag_mem[foot] = TAG_W'(sz);
            end
            if (int'(scan_ptr) > head) scan_ptr = SRCH_W'(head);
            r.granted = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < HEAP_WORDS; i++) tag_mem[i] = '0;
         tag_mem[0] = TAG_W'(HEAP_WORDS - TAG_OVERHEAD);
         tag_mem[HEAP_WORDS - 1] = TAG_W'(HEAP_WORDS - TAG_OVERHEAD);
         scan_ptr = '0;
         expected_replies.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("reply word with none outstanding: addr %0d granted %0b",
                                         rsp_word.data_address, rsp_word.granted));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_word.data_address !== want.data_address)
                  report_mismatch($sformatf("data_address got %0d expected %0d",
                                            rsp_word.data_address, want.data_address));
               if (rsp_word.granted !== want.granted)
                  report_mismatch($sformatf("granted got %0b expected %0b",
                                            rsp_word.granted, want.granted));
            end
         end
         if (start && !busy) expected_replies.push_back(heap_step(req_word));
      end
      leftover <= expected_replies.size();
   end

endmodule

`default_nettype wire

// File: test/boundary_tag_heap_allocator_tb.sv
`default_nettype none

module boundary_tag_heap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bta_pkg::*;

   localparam int RANDOM_ITEMS   = 1027;
   localparam int WATCHDOG_LIMIT = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_word  = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;
   int      mismatches;
   int      leftover;
   int      quiet     = 0;

   logic [ADDR_W-1:0] live_blocks [$];
   req_type           pending_words [$];
   logic              calm = 1'b0;

   boundary_tag_heap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   heap_alloc_checker chk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .mismatches (mismatches),
      .leftover   (leftover)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // granted allocations become candidates for later frees
   task automatic tick();
      @(posedge clock);
      if (rsp_valid && pending_words.size() != 0) begin
         if (pending_words[0].op == OP_ALLOC && rsp_word.granted)
            live_blocks.push_back(rsp_word.data_address);
         void'(pending_words.pop_front());
      end
   endtask

   task automatic drain();
      if (pending_words.size() != 0) begin
         start <= 1'b0;
         do tick(); while (pending_words.size() != 0);
      end
   endtask

   task automatic send_word(input req_type w);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 6) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) tick();
      end
      if (w.op == OP_FREE) begin
         for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == w.block_address) begin
               live_blocks.delete(i);
               break;
            end
         end
      end
      req_word <= w;
      start <= 1'b1;
      do tick(); while (busy);
      pending_words.push_back(w);
   endtask

   // frees wait for all replies so the live list is exact
   task automatic send_cmd(input op_type op, input int bytes, input int addr);
      req_type w;
      w.op = op;
      w.request_bytes = BYTES_W'(bytes);
      w.block_address = ADDR_W'(addr);
      if (op == OP_FREE) drain();
      send_word(w);
   endtask

   initial begin
      req_type           w;
      int                pick;
      int                free_share;
      logic              again_valid;
      logic [ADDR_W-1:0] again_addr;
      again_valid = 1'b0;
      again_addr = '0;

      repeat (8) tick();
      reset <= 1'b0;

      send_cmd(OP_ALLOC, 0, 0);
      send_cmd(OP_ALLOC, 65535, 0);
      send_cmd(OP_ALLOC, 4088, 0);
      send_cmd(OP_ALLOC, 4, 0);
      send_cmd(OP_FREE, 0, 1);
      send_cmd(OP_FREE, 0, 1);
      send_cmd(OP_FREE, 0, 0);
      send_cmd(OP_ALLOC, 4077, 0);
      send_cmd(OP_FREE, 0, 1);
      send_cmd(OP_ALLOC, 4076, 0);
      send_cmd(OP_ALLOC, 1, 0);
      send_cmd(OP_FREE, 0, 1022);
      send_cmd(OP_FREE, 0, 1);
      send_cmd(OP_ALLOC, 8, 0);
      send_cmd(OP_ALLOC, 3, 0);
      send_cmd(OP_ALLOC, 12, 0);
      send_cmd(OP_FREE, 0, 5);
      send_cmd(OP_ALLOC, 4, 0);
      send_cmd(OP_FREE, 0, 8);
      send_cmd(OP_FREE, 0, 1);
      send_cmd(OP_FREE, 0, 5);
      send_cmd(OP_ALLOC, 65535, 0);
      send_cmd(OP_ALLOC, 40, 0);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 550);
         if (n == 700) drain();
         w.request_bytes = BYTES_W'($urandom_range(0, 65535));
         w.block_address = ADDR_W'($urandom_range(0, 1023));
         if (again_valid) begin
            w.op = OP_FREE;
            w.block_address = again_addr;
            again_valid = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            free_share = (live_blocks.size() > 40) ? 60 : 35;
            if (pick < 3) begin
               w.op = OP_FREE;
               w.block_address = '0;
            end else if (live_blocks.size() != 0 && pick < 3 + free_share) begin
               w.op = OP_FREE;
               w.block_address = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
               again_valid = ($urandom_range(0, 99) < 5);
               again_addr = w.block_address;
            end else begin
               w.op = OP_ALLOC;
               pick = $urandom_range(0, 99);
               if (pick < 75) w.request_bytes = BYTES_W'($urandom_range(1, 64));
               else if (pick < 92) w.request_bytes = BYTES_W'($urandom_range(65, 800));
               else if (pick >= 97) w.request_bytes = '0;
            end
         end
         send_word(w);
      end

      drain();
      repeat (20) tick();
      if (mismatches == 0 && leftover == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/bta_pkg.sv
rtl/bta_ram.sv
rtl/boundary_tag_heap_allocator.sv
test/heap_alloc_checker.sv
test/boundary_tag_heap_allocator_tb.sv
